>>> sv/tgah_pkg.sv
// tgah_pkg: shared types and constants for the tile grid average hash block.
// No dependencies; compiled first.
`default_nettype none

package tgah_pkg;

  localparam int GRID        = 8;
  localparam int GRID_W      = 3;
  localparam int SAMPLES     = GRID * GRID;
  localparam int STORE_DEPTH = GRID * GRID * GRID;
  localparam int STORE_AW    = 3 * GRID_W;
  localparam int GRAY_W      = 8;
  localparam int SCALE_SH    = 6;
  localparam int SUM_W       = GRAY_W + SCALE_SH;
  localparam int CSUM_W      = 10;
  localparam int DIV3_W      = 10;
  localparam int DIV3_MUL    = 683;
  localparam int DIV3_SHIFT  = 11;
  localparam int MIN_DIM     = 64;
  localparam int HASH_W      = 64;
  localparam int TILE_IDX_W  = 6;
  localparam int SWEEP_W     = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int BYTE_W      = 8;
  localparam int BPP_W       = 3;
  localparam int BPP_MAX     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

  typedef struct packed {
    logic accept;
    logic sweep_run;
    logic out_load;
  } tgah_cmd_t;

  typedef struct packed {
    logic tile_done;
    logic sweep_last;
    logic out_free;
  } tgah_status_t;

endpackage

`default_nettype wire

>>> sv/tgah_if.sv
// tgah_if: valid/ready channels of the block (byte in, hash out, config write).
// Depends on tgah_pkg.
`default_nettype none

interface tgah_byte_if import tgah_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  modport source (output valid, output byte_value, input ready);
  modport sink (input valid, input byte_value, output ready);
endinterface

interface tgah_hash_if import tgah_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [HASH_W-1:0]     tile_hash;
  logic [TILE_IDX_W-1:0] tile_index;
  logic                  image_done;
  modport source (output valid, output tile_hash, output tile_index, output image_done,
                  input ready);
  modport sink (input valid, input tile_hash, input tile_index, input image_done,
                output ready);
endinterface

interface tgah_cfg_if import tgah_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;
  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

>>> sv/tgah_ctrl.sv
// tgah_ctrl: sequencer for byte intake, hash sweep and result load.
// Depends on tgah_pkg.
`default_nettype none

module tgah_ctrl import tgah_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  tgah_status_t status,
  output tgah_cmd_t    cmd
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    in_ready      = (state == ST_RUN);
    cmd.accept    = in_valid && (state == ST_RUN);
    cmd.sweep_run = (state == ST_SWEEP);
    cmd.out_load  = (state == ST_LOAD) && status.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (cmd.accept && status.tile_done) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (status.sweep_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/tgah_datapath.sv
// tgah_datapath: config registers, raster position tracking, gray store,
// per-column tile sums, hash sweep and output register. Depends on tgah_pkg.
`default_nettype none

module tgah_datapath import tgah_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [BYTE_W-1:0]     in_byte,
  input  tgah_cmd_t                  cmd,
  output tgah_status_t               status,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [HASH_W-1:0]          out_hash,
  output logic [TILE_IDX_W-1:0]      out_index,
  output logic                       out_done
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int POS_W = $clog2(MAX_DIM);
  localparam int TW_W  = DIM_W - 3;
  localparam int CMP_W = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
  localparam int PROD_W = CSUM_W + DIV3_W;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    if (vx < CMP_W'(MIN_DIM)) return DIM_W'(MIN_DIM);
    if (vx > CMP_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return DIM_W'(vx);
  endfunction

  // config
  logic [DIM_W-1:0] width_cfg;
  logic [DIM_W-1:0] height_cfg;
  logic             four_ch;
  logic             cfg_hit;

  assign cfg_hit = cfg_valid && (cfg_index == REG_IMAGE_WIDTH ||
                                 cfg_index == REG_IMAGE_HEIGHT ||
                                 cfg_index == REG_BYTES_PER_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= DIM_W'(MIN_DIM);
      height_cfg <= DIM_W'(MIN_DIM);
      four_ch    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     width_cfg  <= clamp_dim(cfg_data);
        REG_IMAGE_HEIGHT:    height_cfg <= clamp_dim(cfg_data);
        REG_BYTES_PER_PIXEL: four_ch    <= (cfg_data[BPP_W-1:0] >= BPP_W'(BPP_MAX));
        default: ;
      endcase
    end
  end

  logic [TW_W-1:0] tw;
  logic [TW_W-1:0] th;
  assign tw = width_cfg[DIM_W-1:3];
  assign th = height_cfg[DIM_W-1:3];

  // stream position
  logic [1:0]        chan;
  logic [CSUM_W-1:0] csum;
  logic [POS_W-1:0]  col_pos;
  logic [POS_W-1:0]  row_pos;
  logic [TW_W-1:0]   off_x;
  logic [TW_W-1:0]   off_y;
  logic [3:0]        kx;
  logic [3:0]        ky;
  logic [DIM_W-1:0]  acc_x;
  logic [DIM_W-1:0]  acc_y;
  logic [3:0]        tx;
  logic [3:0]        ty;

  logic              pixel_end;
  logic [CSUM_W-1:0] csum_total;
  logic [PROD_W-1:0] prod;
  logic [GRAY_W-1:0] gray;
  logic              hit_x;
  logic              hit_y;
  logic              in_grid;
  logic              sample;
  logic              tile_done;
  logic              col_last;
  logic              row_last;
  logic              off_x_last;
  logic              off_y_last;
  logic              image_end;

  assign pixel_end  = four_ch ? (chan == 2'd3) : (chan == 2'd2);
  assign csum_total = csum + ((chan != 2'd3) ? CSUM_W'(in_byte) : '0);
  // divide by three: reciprocal multiply, exact for sums up to 765
  assign prod       = PROD_W'(csum_total) * PROD_W'(DIV3_MUL);
  assign gray       = prod[DIV3_SHIFT +: GRAY_W];

  assign hit_x   = (kx < 4'(GRID)) && (off_x == acc_x[DIM_W-1:3]);
  assign hit_y   = (ky < 4'(GRID)) && (off_y == acc_y[DIM_W-1:3]);
  assign in_grid = (tx < 4'(GRID)) && (ty < 4'(GRID));
  assign sample  = pixel_end && in_grid && hit_x && hit_y;
  assign tile_done = sample && (kx == 4'(GRID - 1)) && (ky == 4'(GRID - 1));

  assign col_last   = (DIM_W'(col_pos) + DIM_W'(1)) == width_cfg;
  assign row_last   = (DIM_W'(row_pos) + DIM_W'(1)) == height_cfg;
  assign off_x_last = ((TW_W+1)'(off_x) + (TW_W+1)'(1)) == (TW_W+1)'(tw);
  assign off_y_last = ((TW_W+1)'(off_y) + (TW_W+1)'(1)) == (TW_W+1)'(th);
  assign image_end  = pixel_end && col_last && row_last;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      chan    <= '0;
      csum    <= '0;
      col_pos <= '0;
      row_pos <= '0;
      off_x   <= '0;
      off_y   <= '0;
      kx      <= '0;
      ky      <= '0;
      acc_x   <= '0;
      acc_y   <= '0;
      tx      <= '0;
      ty      <= '0;
    end else if (cmd.accept) begin
      if (!pixel_end) begin
        chan <= chan + 2'd1;
        csum <= csum_total;
      end else begin
        chan <= '0;
        csum <= '0;
        if (!col_last) begin
          col_pos <= col_pos + POS_W'(1);
          if (off_x_last) begin
            off_x <= '0;
            kx    <= '0;
            acc_x <= '0;
            tx    <= tx + 4'd1;
          end else begin
            off_x <= off_x + TW_W'(1);
            if (hit_x) begin
              kx    <= kx + 4'd1;
              acc_x <= acc_x + DIM_W'(tw);
            end
          end
        end else begin
          col_pos <= '0;
          off_x   <= '0;
          kx      <= '0;
          acc_x   <= '0;
          tx      <= '0;
          if (!row_last) begin
            row_pos <= row_pos + POS_W'(1);
            if (off_y_last) begin
              off_y <= '0;
              ky    <= '0;
              acc_y <= '0;
              ty    <= ty + 4'd1;
            end else begin
              off_y <= off_y + TW_W'(1);
              if (hit_y) begin
                ky    <= ky + 4'd1;
                acc_y <= acc_y + DIM_W'(th);
              end
            end
          end else begin
            row_pos <= '0;
            off_y   <= '0;
            ky      <= '0;
            acc_y   <= '0;
            ty      <= '0;
          end
        end
      end
    end
  end

  // tile sums, one per tile column
  logic [SUM_W-1:0] tsum [GRID];
  logic [SUM_W-1:0] sum_new;

  assign sum_new = tsum[tx[GRID_W-1:0]] + SUM_W'(gray);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit || (cmd.accept && image_end)) begin
      for (int i = 0; i < GRID; i++) tsum[i] <= '0;
    end else if (cmd.accept && sample) begin
      tsum[tx[GRID_W-1:0]] <= tile_done ? '0 : sum_new;
    end
  end

  // gray store
  logic [GRAY_W-1:0]   gray_mem [STORE_DEPTH];
  logic [GRAY_W-1:0]   rd_data;
  logic [GRID_W-1:0]   sweep_tx;
  logic [SWEEP_W-1:0]  cnt;
  logic [SUM_W-1:0]    sweep_sum;
  logic [TILE_IDX_W-1:0] sweep_idx;
  logic [HASH_W-1:0]   hash_acc;
  logic                cmp;

  always_ff @(posedge clk) begin
    if (cmd.accept && sample) begin
      gray_mem[{tx[GRID_W-1:0], ky[GRID_W-1:0], kx[GRID_W-1:0]}] <= gray;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= gray_mem[{sweep_tx, cnt[2*GRID_W-1:0]}];
  end

  assign cmp = {rd_data, SCALE_SH'(0)} >= sweep_sum;

  always_ff @(posedge clk) begin
    if (cmd.accept && tile_done) begin
      sweep_tx  <= tx[GRID_W-1:0];
      sweep_sum <= sum_new;
      sweep_idx <= {ty[GRID_W-1:0], tx[GRID_W-1:0]};
      cnt       <= '0;
    end else if (cmd.sweep_run) begin
      cnt <= cnt + SWEEP_W'(1);
      // read data is registered, so it lags the address
      if (cnt != '0) hash_acc <= {cmp, hash_acc[HASH_W-1:1]};
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hash  <= hash_acc;
      out_index <= sweep_idx;
      out_done  <= &sweep_idx;
    end
  end

  always_comb begin
    status.tile_done  = tile_done;
    status.sweep_last = (cnt == SWEEP_W'(SAMPLES));
    status.out_free   = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

>>> sv/tile_grid_average_hash.sv
// tile_grid_average_hash: top level, joins the sequencer and the datapath.
// Depends on tgah_pkg, tgah_if, tgah_ctrl, tgah_datapath.
//
// Takes an interleaved 3- or 4-channel raster one channel byte per word and
// returns, for each of the 8x8 tiles, a 64-bit average hash with the tile
// number; image_done marks the last tile. Bytes are taken one per cycle. When
// a byte completes a tile, intake stops while the tile's 64 grays are read
// back through the single read port of the gray store and compared against
// the tile sum and while the output register is loaded, longer if the
// previous hash word has not yet been taken. Config writes restart the stream
// and are to be issued between images; no clearing pass follows reset.
`default_nettype none

module tile_grid_average_hash import tgah_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input wire logic    clk,
  input wire logic    rst,
  tgah_byte_if.sink   pixel_in,
  tgah_hash_if.source hash_out,
  tgah_cfg_if.sink    cfg
);

  tgah_cmd_t    cmd;
  tgah_status_t status;
  logic         in_ready;

  assign pixel_in.ready = in_ready;
  assign cfg.ready      = 1'b1;

  tgah_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tgah_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.reg_index),
    .cfg_data  (cfg.write_data),
    .in_byte   (pixel_in.byte_value),
    .cmd       (cmd),
    .status    (status),
    .out_ready (hash_out.ready),
    .out_valid (hash_out.valid),
    .out_hash  (hash_out.tile_hash),
    .out_index (hash_out.tile_index),
    .out_done  (hash_out.image_done)
  );

endmodule

`default_nettype wire

>>> sv/tgah_checker.sv
// tgah_checker: port-level assertions for tile_grid_average_hash, with bind.
// Depends on tgah_pkg and the top level.
`default_nettype none

module tgah_checker import tgah_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [HASH_W-1:0]     tile_hash,
  input wire logic [TILE_IDX_W-1:0] tile_index,
  input wire logic                  image_done
);

  // stalled hash word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tile_hash) &&
      $stable(tile_index) && $stable(image_done))
    else $error("hash word changed while stalled");

  a_last_tile: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |-> tile_index == TILE_IDX_W'(SAMPLES - 1))
    else $error("image_done on a tile other than the last");

  // a new word only appears after a sweep, while intake is held
  a_word_after_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("hash word without a preceding sweep");

  a_sweep_len: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> ##64 !in_ready)
    else $error("sweep shorter than the tile");

endmodule

bind tile_grid_average_hash tgah_checker u_tgah_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pixel_in.ready),
  .out_valid  (hash_out.valid),
  .out_ready  (hash_out.ready),
  .tile_hash  (hash_out.tile_hash),
  .tile_index (hash_out.tile_index),
  .image_done (hash_out.image_done)
);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for tile_grid_average_hash, fed one channel byte per word.
// Uses tgah_pkg and the tgah_if channels; predicts each tile hash word in-bench.

module testbench;
  import tgah_pkg::*;

  localparam int MAX_SIDE      = 4096;
  localparam int MAX_GAP       = 18;
  localparam int SETTLE_CYCLES = 100;
  localparam int BYTES_64      = 64 * 64 * 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum {PACE_BURST, PACE_SPARSE, PACE_FULL} pace_t;
  typedef enum {CONTENT_RANDOM, CONTENT_FLAT, CONTENT_NOISY, CONTENT_EXTREME} content_t;

  typedef struct packed {
    logic [HASH_W-1:0]     hash;
    logic [TILE_IDX_W-1:0] index;
    logic                  done;
  } tile_hash_t;

  logic clk = 1'b0;
  logic rst;

  tgah_byte_if pixel_bus ();
  tgah_hash_if hash_bus ();
  tgah_cfg_if  cfg_bus ();

  tile_grid_average_hash #(.MAX_DIM(MAX_SIDE)) DUT (
    .clk      (clk),
    .rst      (rst),
    .pixel_in (pixel_bus),
    .hash_out (hash_bus),
    .cfg      (cfg_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [CFG_DATA_W-1:0] width_cfg;
  logic [CFG_DATA_W-1:0] height_cfg;
  logic [BPP_W-1:0]      depth_cfg;
  logic [GRAY_W-1:0]     gray_mem [STORE_DEPTH];
  logic [SUM_W-1:0]      tile_col_sums [GRID];
  int unsigned           col_pos, row_pos, chan_pos, color_acc;

  tile_hash_t pending_hashes[$];
  int         fail_count = 0;
  pace_t      send_pace = PACE_FULL;
  pace_t      take_pace = PACE_FULL;
  bit         hold_for_results = 1'b0;
  logic [7:0] flat_level = 8'd0;

  function automatic int unsigned clamp_side(logic [CFG_DATA_W-1:0] v);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  // k-th sample of a tile of size sz sits at floor(k*sz/8)
  function automatic bit sample_offset(int unsigned off, int unsigned sz,
                                       output int unsigned k);
    k = (off * GRID + sz - 1) / sz;
    return (k < GRID) && ((k * sz) / GRID == off);
  endfunction

  function automatic int draw_gap(pace_t p);
    case (p)
      PACE_BURST:  return 0;
      PACE_SPARSE: return ($urandom_range(3) == 0) ? $urandom_range(MAX_GAP) : 0;
      default:     return $urandom_range(MAX_GAP);
    endcase
  endfunction

  function automatic logic [7:0] pick_byte(content_t c);
    case (c)
      CONTENT_FLAT:    return flat_level;
      CONTENT_NOISY:   return flat_level + 8'($urandom_range(2));
      CONTENT_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      default:         return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic restart_position();
    foreach (tile_col_sums[i]) tile_col_sums[i] = '0;
    col_pos   = 0;
    row_pos   = 0;
    chan_pos  = 0;
    color_acc = 0;
  endtask

  task automatic retune(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH:     width_cfg  = data;
      REG_IMAGE_HEIGHT:    height_cfg = data;
      REG_BYTES_PER_PIXEL: depth_cfg  = data[BPP_W-1:0];
      default:             return;
    endcase
    restart_position();
  endtask

  task automatic predict_byte(logic [7:0] b);
    int unsigned side_w, side_h, bpp, tw, th, tx, ty, sx, sy, gray, base;
    tile_hash_t  t;
    side_w = clamp_side(width_cfg);
    side_h = clamp_side(height_cfg);
    bpp    = (depth_cfg < 3) ? 3 : ((depth_cfg > BPP_MAX) ? BPP_MAX : depth_cfg);
    tw     = side_w / GRID;
    th     = side_h / GRID;
    if (chan_pos < 3) color_acc += b;
    if (chan_pos + 1 < bpp) begin
      chan_pos++;
      return;
    end
    gray      = color_acc / 3;
    chan_pos  = 0;
    color_acc = 0;
    if (col_pos < tw * GRID && row_pos < th * GRID) begin
      tx = col_pos / tw;
      ty = row_pos / th;
      if (sample_offset(col_pos - tx * tw, tw, sx) &&
          sample_offset(row_pos - ty * th, th, sy)) begin
        base = tx * SAMPLES;
        gray_mem[base + sy * GRID + sx] = GRAY_W'(gray);
        tile_col_sums[tx] = SUM_W'(tile_col_sums[tx] + gray);
        if (sx == GRID - 1 && sy == GRID - 1) begin
          for (int i = 0; i < SAMPLES; i++)
            t.hash[i] = (int'(gray_mem[base + i]) * SAMPLES >= int'(tile_col_sums[tx]));
          t.index = TILE_IDX_W'(ty * GRID + tx);
          t.done  = (ty * GRID + tx == SAMPLES - 1);
          pending_hashes.push_back(t);
          tile_col_sums[tx] = '0;
        end
      end
    end
    if (col_pos + 1 < side_w) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (row_pos + 1 < side_h) row_pos++;
      else restart_position();
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = draw_gap(send_pace);
    if (gap > 0) begin
      pixel_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_bus.valid      <= 1'b1;
    pixel_bus.byte_value <= b;
    do @(posedge clk); while (!pixel_bus.ready);
    predict_byte(b);
    if (hold_for_results && pending_hashes.size() != 0) begin
      pixel_bus.valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clk);
    end
  endtask

  task automatic stream_bytes(int count, content_t c);
    for (int i = 0; i < count; i++) send_byte(pick_byte(c));
  endtask

  task automatic settle();
    pixel_bus.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.reg_index  <= idx;
    cfg_bus.write_data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    retune(idx, data);
  endtask

  task automatic set_geometry(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                              logic [CFG_DATA_W-1:0] d);
    put_reg(REG_IMAGE_WIDTH, w);
    put_reg(REG_IMAGE_HEIGHT, h);
    put_reg(REG_BYTES_PER_PIXEL, d);
    cfg_bus.valid <= 1'b0;
  endtask

  // reset geometry, corner bytes, then a spare index write that must not restart
  task automatic test_reset_geometry();
    logic [7:0] corner_bytes [24];
    corner_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                     8'hFF, 8'hFF, 8'hFE, 8'h01, 8'h01, 8'h00,
                     8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                     8'h80, 8'h7F, 8'h01, 8'hFE, 8'hFF, 8'h00};
    send_pace = PACE_FULL;
    take_pace = PACE_FULL;
    foreach (corner_bytes[i]) send_byte(corner_bytes[i]);
    settle();
    put_reg(REG_SPARE, '1);
    cfg_bus.valid <= 1'b0;
    stream_bytes(BYTES_64 - 24, CONTENT_RANDOM);
    settle();
  endtask

  // back-to-back images with ties and extremes; the noisy one holds for results
  task automatic test_flat_images();
    set_geometry(13'd64, 13'd64, 13'd3);
    send_pace = PACE_SPARSE;
    flat_level = 8'($urandom_range(255));
    stream_bytes(BYTES_64, CONTENT_FLAT);
    hold_for_results = 1'b1;
    flat_level = 8'($urandom_range(253));
    stream_bytes(BYTES_64, CONTENT_NOISY);
    hold_for_results = 1'b0;
    stream_bytes(BYTES_64, CONTENT_EXTREME);
    settle();
  endtask

  task automatic test_four_channels();
    set_geometry(13'd64, 13'd64, 13'd4);
    send_pace = PACE_SPARSE;
    stream_bytes(64 * 64 * 4, CONTENT_RANDOM);
    settle();
  endtask

  // unsampled right columns and bottom rows, channel count clamped, restart mid-image
  task automatic test_uneven_geometry();
    set_geometry(13'd100, 13'd71, 13'd7);
    send_pace = PACE_BURST;
    take_pace = PACE_BURST;
    stream_bytes(100 * 71 * 4 * 3 / 2, CONTENT_RANDOM);
    settle();
    set_geometry(13'd100, 13'd71, 13'd7);
    take_pace = PACE_FULL;
    stream_bytes(100 * 71 * 4, CONTENT_RANDOM);
    settle();
  endtask

  task automatic test_tall_image();
    set_geometry(13'd5, 13'h1FFF, 13'd0);
    send_pace = PACE_BURST;
    stream_bytes(449 * 64 * 3, CONTENT_RANDOM);
    settle();
  endtask

  task automatic test_wide_image();
    set_geometry(13'(MAX_SIDE), 13'd64, 13'd3);
    send_pace = PACE_BURST;
    stream_bytes(8 * MAX_SIDE * 3, CONTENT_RANDOM);
    settle();
  endtask

  initial begin
    tile_hash_t want;
    int         stall;
    hash_bus.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    hash_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hash_bus.valid === 1'b1 && hash_bus.ready === 1'b1) begin
        if (pending_hashes.size() == 0) begin
          $error("unexpected hash word: tile_index %0d", hash_bus.tile_index);
          fail_count++;
        end else begin
          want = pending_hashes.pop_front();
          if (hash_bus.tile_hash !== want.hash) begin
            $error("tile_hash: expected %h, actual %h", want.hash, hash_bus.tile_hash);
            fail_count++;
          end
          if (hash_bus.tile_index !== want.index) begin
            $error("tile_index: expected %0d, actual %0d", want.index, hash_bus.tile_index);
            fail_count++;
          end
          if (hash_bus.image_done !== want.done) begin
            $error("image_done: expected %b, actual %b", want.done, hash_bus.image_done);
            fail_count++;
          end
        end
        stall = draw_gap(take_pace);
        if (stall > 0) begin
          hash_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          hash_bus.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #1_000_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst                  = 1'b1;
    pixel_bus.valid      = 1'b0;
    pixel_bus.byte_value = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.reg_index    = REG_IMAGE_WIDTH;
    cfg_bus.write_data   = '0;
    width_cfg            = 13'(MIN_DIM);
    height_cfg           = 13'(MIN_DIM);
    depth_cfg            = 3'd3;
    restart_position();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_geometry();
    test_flat_images();
    test_four_channels();
    test_uneven_geometry();
    test_tall_image();
    test_wide_image();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/tgah_pkg.sv
sv/tgah_if.sv
sv/tgah_ctrl.sv
sv/tgah_datapath.sv
sv/tile_grid_average_hash.sv
sv/tgah_checker.sv
tb/sv/testbench.sv
